// ===== src/lgs_pkg.sv =====
// shared types, constants and command codes for the life grid generation step core
package lgs_pkg;

    // default geometry and counter sizes
    localparam int LGS_GRID_WIDTH  = 64;
    localparam int LGS_GRID_HEIGHT = 64;
    localparam int LGS_HEAT_BITS   = 16;
    localparam int LGS_COUNT_BITS  = 32;

    // b3/s23 neighbour counts
    localparam int BIRTH_COUNT = 3;
    localparam int STAY_LOW    = 2;

    // command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] col;
        logic [5:0] row;
        logic       alive_in;
    } t_req;

    // response payload
    typedef struct packed {
        logic        alive_out;
        logic [15:0] heat_out;
        logic [31:0] population;
        logic [31:0] deaths;
        logic [31:0] births;
    } t_rsp;

    // outcome for the cell at the centre of the window
    typedef struct packed {
        logic alive;
        logic born;
        logic died;
    } t_fate;

endpackage

// ===== src/lgs_ram.sv =====
// generic simple dual port ram with registered read
module lgs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lgs_chain_cell.sv =====
// one cell of the old-value chain: holds a grid bit and passes it on each shift
module lgs_chain_cell (
    input  logic i_clk,
    input  logic i_clear,
    input  logic i_shift,
    input  logic i_d,
    output logic o_q
);

    logic r_bit;

    // clear takes priority so the chain starts empty above the top row
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_d;
        end
    end

    assign o_q = r_bit;

endmodule

// ===== src/lgs_window.sv =====
// two-row chain of cells with 3x3 window taps and the b3/s23 rule
module lgs_window
    import lgs_pkg::*;
#(
    parameter int GRID_WIDTH = LGS_GRID_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_clear,
    input  logic  i_shift,
    input  logic  i_din,
    input  logic  i_edge_left,
    input  logic  i_edge_right,
    output t_fate o_fate
);

    localparam int CHAIN_LEN = 2 * GRID_WIDTH + 2;

    logic [CHAIN_LEN-1:0] q;
    logic [7:0]           nb;
    logic [3:0]           n_live;
    logic                 centre;

    // chain: cell i holds the value streamed i+1 steps ago
    for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_chain
        lgs_chain_cell u_cell (
            .i_clk   (i_clk),
            .i_clear (i_clear),
            .i_shift (i_shift),
            .i_d     ((g == 0) ? i_din : q[(g == 0) ? 0 : g - 1]),
            .o_q     (q[g])
        );
    end

    // neighbours of the centre, masked at the left and right edges
    always_comb begin
        centre = q[GRID_WIDTH];
        nb[0]  = i_din                  & ~i_edge_right;
        nb[1]  = q[0];
        nb[2]  = q[1]                   & ~i_edge_left;
        nb[3]  = q[GRID_WIDTH-1]        & ~i_edge_right;
        nb[4]  = q[GRID_WIDTH+1]        & ~i_edge_left;
        nb[5]  = q[2*GRID_WIDTH-1]      & ~i_edge_right;
        nb[6]  = q[2*GRID_WIDTH];
        nb[7]  = q[2*GRID_WIDTH+1]      & ~i_edge_left;
        n_live = 4'($countones(nb));
    end

    // survival and birth rule
    always_comb begin
        o_fate.died  = centre && (n_live != 4'(STAY_LOW)) && (n_live != 4'(BIRTH_COUNT));
        o_fate.born  = !centre && (n_live == 4'(BIRTH_COUNT));
        o_fate.alive = (centre && !o_fate.died) || o_fate.born;
    end

endmodule

// ===== src/life_grid_generation_step_core.sv =====
// top level: bounded b3/s23 grid with cell heat and running totals
//
//  channel    | direction | valid       | ready       | payload
//  -----------+-----------+-------------+-------------+------------------
//  request    | in        | i_in_valid  | o_in_ready  | i_in_data (t_req)
//  response   | out       | o_out_valid | i_out_ready | o_out_data (t_rsp)
//
// after reset a clearing pass writes every grid and heat entry with o_in_ready low.
// write, read and the unused code pass from idle through the response state into the
// output register. an advance streams the grid through the cell chain one cell a
// cycle, set by the single read port of the grid ram. one request is worked at a time;
// a new one is taken while an earlier response waits in the output register.
module life_grid_generation_step_core
    import lgs_pkg::*;
#(
    parameter int GRID_WIDTH  = LGS_GRID_WIDTH,
    parameter int GRID_HEIGHT = LGS_GRID_HEIGHT,
    parameter int HEAT_BITS   = LGS_HEAT_BITS,
    parameter int COUNT_BITS  = LGS_COUNT_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW     = $clog2(NCELLS);
    localparam int SW     = $clog2(NCELLS + GRID_WIDTH + 1);
    localparam int CW     = $clog2(NCELLS + 1);
    localparam int COLW   = $clog2(GRID_WIDTH);

    localparam logic [SW-1:0]   SWEEP_LAST = SW'(NCELLS + GRID_WIDTH);
    localparam logic [SW-1:0]   LAG        = SW'(GRID_WIDTH + 1);
    localparam logic [SW-1:0]   CLEAR_LAST = SW'(NCELLS - 1);
    localparam logic [SW-1:0]   PAD_START  = SW'(NCELLS);
    localparam logic [COLW-1:0] COL_LAST   = COLW'(GRID_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FETCH,
        ST_RESP
    } t_state;

    t_state                r_state;
    logic [SW-1:0]         r_addr;
    logic                  r_s1_valid;
    logic                  r_s1_pad;
    logic                  r_s1_centre;
    logic [CW-1:0]         r_ctr_addr;
    logic [COLW-1:0]       r_ctr_col;
    logic [AW-1:0]         r_idx;
    logic                  r_inside;
    logic                  r_is_write;
    logic                  r_alive_wr;
    logic [COUNT_BITS-1:0] r_live;
    logic [COUNT_BITS-1:0] r_deaths;
    logic [COUNT_BITS-1:0] r_births;
    logic                  r_out_valid;
    t_rsp                  r_out_data;

    logic                  accept;
    logic                  req_inside;
    logic [AW-1:0]         req_idx;
    logic                  proc;
    t_fate                 fate;
    logic                  chain_din;

    logic                  grid_we;
    logic [AW-1:0]         grid_waddr;
    logic                  grid_wdata;
    logic                  grid_re;
    logic [AW-1:0]         grid_raddr;
    logic                  grid_rdata;
    logic                  heat_we;
    logic [AW-1:0]         heat_waddr;
    logic [HEAT_BITS-1:0]  heat_wdata;
    logic                  heat_re;
    logic [AW-1:0]         heat_raddr;
    logic [HEAT_BITS-1:0]  heat_rdata;
    logic [SW-1:0]         heat_lag_addr;

    // request decode
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign req_inside = (32'(i_in_data.col) < 32'(GRID_WIDTH))
                     && (32'(i_in_data.row) < 32'(GRID_HEIGHT));
    assign req_idx    = AW'(AW'(i_in_data.row) * AW'(GRID_WIDTH)) + AW'(i_in_data.col);

    // centre processing happens in the cycle after each sweep step from address LAG on
    assign proc          = r_s1_valid && r_s1_centre;
    assign chain_din     = r_s1_pad ? 1'b0 : grid_rdata;
    assign heat_lag_addr = r_addr - LAG;

    lgs_window #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_clear      (accept && (i_in_data.cmd == CMD_ADVANCE)),
        .i_shift      (r_s1_valid),
        .i_din        (chain_din),
        .i_edge_left  (r_ctr_col == '0),
        .i_edge_right (r_ctr_col == COL_LAST),
        .o_fate       (fate)
    );

    // ram port selection
    always_comb begin
        grid_we    = 1'b0;
        grid_waddr = req_idx;
        grid_wdata = i_in_data.alive_in;
        grid_re    = 1'b0;
        grid_raddr = req_idx;
        heat_we    = 1'b0;
        heat_waddr = r_ctr_addr[AW-1:0];
        heat_wdata = (heat_rdata == '1) ? heat_rdata : heat_rdata + 1'b1;
        heat_re    = 1'b0;
        heat_raddr = req_idx;
        case (r_state)
            ST_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = r_addr[AW-1:0];
                grid_wdata = 1'b0;
                heat_we    = 1'b1;
                heat_waddr = r_addr[AW-1:0];
                heat_wdata = '0;
            end
            ST_IDLE: begin
                if (accept && (i_in_data.cmd != CMD_ADVANCE)) begin
                    grid_we = (i_in_data.cmd == CMD_WRITE) && req_inside;
                    grid_re = 1'b1;
                    heat_re = 1'b1;
                end
            end
            ST_SWEEP: begin
                grid_re    = (r_addr < PAD_START);
                grid_raddr = r_addr[AW-1:0];
                heat_re    = (r_addr >= LAG);
                heat_raddr = heat_lag_addr[AW-1:0];
            end
            ST_FETCH: begin
                grid_re    = 1'b1;
                grid_raddr = r_idx;
                heat_re    = 1'b1;
                heat_raddr = r_idx;
            end
            default: begin
            end
        endcase
        // write back of the centre cell during a sweep
        if (proc) begin
            grid_we    = 1'b1;
            grid_waddr = r_ctr_addr[AW-1:0];
            grid_wdata = fate.alive;
            heat_we    = fate.born;
        end
    end

    lgs_ram #(
        .WIDTH (1),
        .DEPTH (NCELLS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (grid_wdata),
        .i_re    (grid_re),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    lgs_ram #(
        .WIDTH (HEAT_BITS),
        .DEPTH (NCELLS)
    ) u_heat_ram (
        .i_clk   (i_clk),
        .i_we    (heat_we),
        .i_waddr (heat_waddr),
        .i_wdata (heat_wdata),
        .i_re    (heat_re),
        .i_raddr (heat_raddr),
        .o_rdata (heat_rdata)
    );

    // sequencer, totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_pad    <= 1'b0;
            r_s1_centre <= 1'b0;
            r_ctr_addr  <= '0;
            r_ctr_col   <= '0;
            r_live      <= '0;
            r_deaths    <= '0;
            r_births    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= 1'b0;
            r_s1_pad    <= 1'b0;
            r_s1_centre <= 1'b0;

            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // totals and centre position follow each processed cell
            if (proc) begin
                r_ctr_addr <= r_ctr_addr + 1'b1;
                r_ctr_col  <= (r_ctr_col == COL_LAST) ? '0 : r_ctr_col + 1'b1;
                if (fate.born) begin
                    r_live   <= (r_live == '1) ? r_live : r_live + 1'b1;
                    r_births <= (r_births == '1) ? r_births : r_births + 1'b1;
                end
                if (fate.died) begin
                    r_live   <= (r_live != '0) ? r_live - 1'b1 : r_live;
                    r_deaths <= (r_deaths == '1) ? r_deaths : r_deaths + 1'b1;
                end
            end

            case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == CLEAR_LAST) begin
                        r_addr  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_idx      <= req_idx;
                        r_inside   <= req_inside;
                        r_is_write <= (i_in_data.cmd == CMD_WRITE);
                        r_alive_wr <= i_in_data.alive_in;
                        if (i_in_data.cmd == CMD_ADVANCE) begin
                            r_addr     <= '0;
                            r_ctr_addr <= '0;
                            r_ctr_col  <= '0;
                            r_state    <= ST_SWEEP;
                        end else begin
                            r_state <= ST_RESP;
                        end
                    end
                end
                ST_SWEEP: begin
                    r_s1_valid  <= 1'b1;
                    r_s1_pad    <= (r_addr >= PAD_START);
                    r_s1_centre <= (r_addr >= LAG);
                    r_addr      <= r_addr + 1'b1;
                    if (r_addr == SWEEP_LAST) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FETCH;
                end
                ST_FETCH: begin
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid           <= 1'b1;
                        r_out_data.alive_out  <= r_inside
                                              && (r_is_write ? r_alive_wr : grid_rdata);
                        r_out_data.heat_out   <= r_inside ? 16'(heat_rdata) : 16'd0;
                        r_out_data.population <= 32'(r_live);
                        r_out_data.deaths     <= 32'(r_deaths);
                        r_out_data.births     <= 32'(r_births);
                        r_state               <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // population only ever grows through births
    a_pop_le_births: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> (r_live <= r_births))
        else $error("population above birth total");

    // a sweep processes exactly every cell before the final read
    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_ctr_addr == CW'(NCELLS)))
        else $error("sweep did not visit every cell");

    // the chain only moves while a sweep is running
    a_chain_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == ST_SWEEP || r_state == ST_DRAIN))
        else $error("chain shift outside a sweep");

    // death and birth totals never fall
    a_totals_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_deaths >= $past(r_deaths)) && (r_births >= $past(r_births)))
        else $error("death or birth total fell");

endmodule
